/* hdl/lrva_pkg.sv */
package lrva_pkg;

   localparam int STATES_DEF     = 8;
   localparam int FRAME_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int STATE_MAX_BITS = 5;
   localparam int FRAME_MAX_BITS = 32;
   localparam int CSR_ADDR_BITS  = 3;

   localparam logic signed [31:0] FLOOR_RESET = -32'sd16777216;
   localparam logic [31:0] RECIP_FIFTH = 32'hCCCCCCCD;
   localparam int RECIP_SHIFT = 34;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_EMIT  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_FLOOR = 3'd0;

   typedef enum logic [2:0] {
      CMD_START,
      CMD_EMIT,
      CMD_RDROW,
      CMD_RDFRAME,
      CMD_RDZERO,
      CMD_ORDER,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic signed [31:0]          score;
      logic [STATE_MAX_BITS-1:0]   state;
      logic [STATE_MAX_BITS-1:0]   col;
      logic [FRAME_MAX_BITS-1:0]   frame;
      logic                        frame_end;
      logic                        started;
   } cmd_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* hdl/lrva_req_if.sv */
interface lrva_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] state_score;
   logic [3:0]  boundary_index;

   modport source (output valid, output op, output state_score, output boundary_index,
                   input ready);
   modport sink (input valid, input op, input state_score, input boundary_index,
                 output ready);
endinterface

/* hdl/lrva_rsp_if.sv */
interface lrva_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] path_score;
   logic [2:0]  state_number;
   logic        frame_end;
   logic [15:0] boundary_frame;
   logic        order_error;

   modport source (output valid, output path_score, output state_number,
                   output frame_end, output boundary_frame, output order_error,
                   input ready);
   modport sink (input valid, input path_score, input state_number,
                 input frame_end, input boundary_frame, input order_error,
                 output ready);
endinterface

/* hdl/lrva_front.sv */
module lrva_front import lrva_pkg::*; #(
   parameter int STATES     = STATES_DEF,
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   lrva_req_if.sink req,
   output cmd_type  cmd,
   output logic     cmd_valid,
   input  logic     cmd_ready
);

   localparam int SB = (STATES > 1) ? $clog2(STATES) : 1;
   localparam logic [SB-1:0] TOP_STATE = SB'(STATES - 1);

   logic [SB-1:0]         expected_ff, expected_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  started_ff, started_in;
   logic                  accept;

   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid;
   assign accept    = req.valid && cmd_ready;

   always_comb begin
      cmd.score     = req.state_score;
      cmd.state     = STATE_MAX_BITS'(TOP_STATE);
      cmd.col       = STATE_MAX_BITS'(req.boundary_index);
      cmd.frame     = FRAME_MAX_BITS'(frame_ff);
      cmd.frame_end = 1'b0;
      cmd.started   = started_ff;
      case (req.op)
         OP_START: begin
            cmd.kind  = CMD_START;
            cmd.state = '0;
         end
         OP_EMIT: begin
            cmd.kind      = started_ff ? CMD_EMIT : CMD_ORDER;
            cmd.state     = STATE_MAX_BITS'(expected_ff);
            cmd.frame_end = started_ff && (expected_ff == '0);
         end
         OP_READ: begin
            if (req.boundary_index != 4'd0 &&
                32'(req.boundary_index) < 32'(STATES)) begin
               cmd.kind = CMD_RDROW;
            end else if (32'(req.boundary_index) == 32'(STATES)) begin
               cmd.kind = CMD_RDFRAME;
            end else begin
               cmd.kind = CMD_RDZERO;
            end
         end
         default: begin
            cmd.kind = CMD_NOP;
         end
      endcase
   end

   always_comb begin
      expected_in = expected_ff;
      frame_in    = frame_ff;
      started_in  = started_ff;
      if (accept) begin
         if (req.op == OP_START) begin
            expected_in = TOP_STATE;
            frame_in    = FRAME_BITS'(1);
            started_in  = 1'b1;
         end else if (req.op == OP_EMIT && started_ff) begin
            if (expected_ff == '0) begin
               expected_in = TOP_STATE;
               frame_in    = frame_ff + FRAME_BITS'(1);
            end else begin
               expected_in = expected_ff - SB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= TOP_STATE;
         frame_ff    <= '0;
         started_ff  <= 1'b0;
      end else begin
         expected_ff <= expected_in;
         frame_ff    <= frame_in;
         started_ff  <= started_in;
      end
   end

endmodule

/* hdl/lrva_queue.sv */
module lrva_queue import lrva_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type in_cmd,
   input  logic    in_valid,
   output logic    in_ready,
   output cmd_type out_cmd,
   output logic    out_valid,
   input  logic    out_ready
);

   localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CB = $clog2(DEPTH + 1);

   cmd_type        slot_ff [DEPTH];
   logic [PB-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CB-1:0]  count_ff, count_in;
   logic           push, pop;

   assign in_ready  = count_ff != CB'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PB'(DEPTH - 1)) ? '0 : wr_ff + PB'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PB'(DEPTH - 1)) ? '0 : rd_ff + PB'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CB'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_cmd;
      end
   end

endmodule

/* hdl/lrva_back.sv */
module lrva_back import lrva_pkg::*; #(
   parameter int STATES     = STATES_DEF,
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  logic signed [31:0] floor_score,
   lrva_rsp_if.source         rsp
);

   localparam int SB = (STATES > 1) ? $clog2(STATES) : 1;
   localparam int RW = STATES * FRAME_BITS;
   localparam logic [SB-1:0] TOP_STATE = SB'(STATES - 1);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_MUL  = 5'b00010,
      B_ADD  = 5'b00100,
      B_READ = 5'b01000,
      B_EXEC = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   cmd_type            cmd_ff;
   logic [SB-1:0]      step_ff;
   logic signed [31:0] chain_ff;
   logic [31:0]        mag_ff;
   logic               neg_ff;
   logic [63:0]        prod_ff;

   logic signed [31:0] path_mem [STATES];
   logic [RW-1:0]      row_mem [STATES];
   logic [STATES-1:0]  rvalid_ff;

   logic signed [31:0] pa_rd_ff, pb_rd_ff;
   logic [RW-1:0]      row_rd_ff;
   logic               rowv_ff;

   logic               out_valid_ff;
   logic signed [31:0] out_ps_ff;
   logic [2:0]         out_sn_ff;
   logic               out_fe_ff;
   logic [15:0]        out_bf_ff;
   logic               out_oe_ff;

   logic               accept;
   logic [SB-1:0]      s_cur, rb_addr;
   logic [31:0]        mag_now;
   logic [32:0]        seed_total;
   logic signed [31:0] seed_val;
   logic               better;
   logic signed [31:0] base, sum;
   logic [RW-1:0]      new_row;
   logic [FRAME_BITS-1:0] col_val;

   logic               path_we;
   logic [SB-1:0]      path_wa;
   logic signed [31:0] path_wd;
   logic               row_we;

   logic               out_we;
   logic signed [31:0] out_ps;
   logic [2:0]         out_sn;
   logic               out_fe;
   logic [15:0]        out_bf;
   logic               out_oe;

   assign cmd_ready = (state_ff == B_IDLE) && (!out_valid_ff || rsp.ready);
   assign accept    = cmd_valid && cmd_ready;

   assign s_cur   = cmd_ff.state[SB-1:0];
   assign rb_addr = (cmd_ff.kind == CMD_EMIT && s_cur != '0) ? s_cur - SB'(1) : s_cur;
   assign mag_now = chain_ff[31] ? 32'(-chain_ff) : 32'(chain_ff);

   always_comb begin
      seed_total = {1'b0, mag_ff} + 33'(prod_ff[63:RECIP_SHIFT]);
      if (!neg_ff) begin
         seed_val = (seed_total > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : seed_total[31:0];
      end else begin
         seed_val = (seed_total > 33'h080000000) ? 32'sh80000000 : 32'(-seed_total);
      end
   end

   always_comb begin
      better  = (s_cur != '0) && (pb_rd_ff > pa_rd_ff);
      base    = better ? pb_rd_ff : pa_rd_ff;
      sum     = sat33({base[31], base} + {cmd_ff.score[31], cmd_ff.score});
      col_val = rowv_ff ? row_rd_ff[cmd_ff.col[SB-1:0]*FRAME_BITS +: FRAME_BITS] : '0;
      for (int i = 0; i < STATES; i++) begin
         if (i >= 1 && i < int'(s_cur)) begin
            new_row[i*FRAME_BITS +: FRAME_BITS] =
               rowv_ff ? row_rd_ff[i*FRAME_BITS +: FRAME_BITS] : '0;
         end else if (i == int'(s_cur)) begin
            new_row[i*FRAME_BITS +: FRAME_BITS] = cmd_ff.frame[FRAME_BITS-1:0];
         end else begin
            new_row[i*FRAME_BITS +: FRAME_BITS] = '0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      path_we  = 1'b0;
      path_wa  = s_cur;
      path_wd  = sum;
      row_we   = 1'b0;
      out_we   = 1'b0;
      out_ps   = '0;
      out_sn   = '0;
      out_fe   = 1'b0;
      out_bf   = '0;
      out_oe   = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (accept) begin
               case (cmd.kind)
                  CMD_START: begin
                     path_we  = 1'b1;
                     path_wa  = '0;
                     path_wd  = cmd.score;
                     out_we   = 1'b1;
                     out_ps   = cmd.score;
                     state_in = B_MUL;
                  end
                  CMD_EMIT, CMD_RDROW, CMD_RDFRAME, CMD_RDZERO: begin
                     state_in = B_READ;
                  end
                  CMD_ORDER: begin
                     out_we = 1'b1;
                     out_oe = 1'b1;
                  end
                  default: begin
                     out_we = 1'b1;
                  end
               endcase
            end
         end
         B_MUL: begin
            state_in = B_ADD;
         end
         B_ADD: begin
            path_we  = 1'b1;
            path_wa  = step_ff;
            path_wd  = seed_val;
            state_in = (step_ff == TOP_STATE) ? B_IDLE : B_MUL;
         end
         B_READ: begin
            state_in = B_EXEC;
         end
         B_EXEC: begin
            out_we   = 1'b1;
            state_in = B_IDLE;
            if (cmd_ff.kind == CMD_EMIT) begin
               path_we = 1'b1;
               row_we  = better;
               out_ps  = sum;
               out_sn  = 3'(s_cur);
               out_fe  = cmd_ff.frame_end;
            end else begin
               out_ps = cmd_ff.started ? pa_rd_ff : '0;
               out_sn = 3'(TOP_STATE);
               if (cmd_ff.kind == CMD_RDROW) begin
                  out_bf = 16'(col_val);
               end else if (cmd_ff.kind == CMD_RDFRAME) begin
                  out_bf = 16'(cmd_ff.frame);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rvalid_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && cmd.kind == CMD_START) begin
            rvalid_ff <= '0;
         end else if (row_we) begin
            rvalid_ff[s_cur] <= 1'b1;
         end
         if (out_we) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd;
         chain_ff <= floor_score;
         step_ff  <= SB'(1);
      end
      if (state_ff == B_MUL) begin
         prod_ff <= mag_now * RECIP_FIFTH;
         mag_ff  <= mag_now;
         neg_ff  <= chain_ff[31];
      end
      if (state_ff == B_ADD) begin
         chain_ff <= seed_val;
         step_ff  <= step_ff + SB'(1);
      end
      if (out_we) begin
         out_ps_ff <= out_ps;
         out_sn_ff <= out_sn;
         out_fe_ff <= out_fe;
         out_bf_ff <= out_bf;
         out_oe_ff <= out_oe;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_READ) begin
         pa_rd_ff  <= path_mem[s_cur];
         pb_rd_ff  <= path_mem[rb_addr];
         row_rd_ff <= row_mem[rb_addr];
         rowv_ff   <= rvalid_ff[rb_addr];
      end
      if (path_we) begin
         path_mem[path_wa] <= path_wd;
      end
      if (row_we) begin
         row_mem[s_cur] <= new_row;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.path_score     = out_ps_ff;
   assign rsp.state_number   = out_sn_ff;
   assign rsp.frame_end      = out_fe_ff;
   assign rsp.boundary_frame = out_bf_ff;
   assign rsp.order_error    = out_oe_ff;

endmodule

/* hdl/left_right_viterbi_aligner_core.sv */
// Frame-synchronous Viterbi aligner over a left-to-right chain of STATES states. One beat in
// gives one beat out. The front takes a request beat every cycle while its command queue
// (QUEUE_DEPTH entries) has room; the back handles an emission or read beat as a registered read
// of the path-score and entry-frame memories, then an update, and a start beat as a seeding
// chain of one multiply step and one add step for each state after state 0. Beats for order
// errors or the unused op are answered straight from the idle state. Rows of the entry
// table carry valid bits cleared by start, so no clearing pass is needed.
module left_right_viterbi_aligner_core import lrva_pkg::*; #(
   parameter int STATES      = STATES_DEF,
   parameter int FRAME_BITS  = FRAME_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   lrva_req_if.sink                 req_bus,
   lrva_rsp_if.source               rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic signed [31:0] floor_ff;
   cmd_type            f_cmd, q_cmd;
   logic               f_valid, f_ready, q_valid, q_ready;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_FLOOR) ? floor_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
      end else if (psel && penable && pwrite && paddr == CSR_FLOOR) begin
         floor_ff <= pwdata;
      end
   end

   lrva_front #(.STATES(STATES), .FRAME_BITS(FRAME_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cmd       (f_cmd),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready)
   );

   lrva_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (f_cmd),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .out_cmd   (q_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready)
   );

   lrva_back #(.STATES(STATES), .FRAME_BITS(FRAME_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (q_cmd),
      .cmd_valid   (q_valid),
      .cmd_ready   (q_ready),
      .floor_score (floor_ff),
      .rsp         (rsp_bus)
   );

   a_order_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.order_error |->
         rsp_bus.path_score == '0 && !rsp_bus.frame_end && rsp_bus.boundary_frame == '0)
      else $error("order error beat carries payload");

   a_frame_end_state0: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.frame_end |-> rsp_bus.state_number == '0)
      else $error("frame end on state other than 0");

   a_full_queue_busy: assert property (@(posedge clock) disable iff (reset)
      !f_ready |-> q_valid)
      else $error("queue full but empty at output");

endmodule

/* bench/lrva_checker.sv */
`timescale 1ns / 1ps

module lrva_checker import lrva_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   lrva_req_if                      req_mon,
   lrva_rsp_if                      rsp_mon,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic                     pready,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output int                       errors,
   output int                       pending
);

   localparam int NSTATES = STATES_DEF;

   typedef struct packed {
      logic signed [31:0] path_score;
      logic [2:0]         state_number;
      logic               frame_end;
      logic [15:0]        boundary_frame;
      logic               order_error;
   } rsp_beat_type;

   logic signed [31:0] floor_reg;
   logic signed [31:0] trellis_score [NSTATES];
   logic [15:0]        entry_frame [NSTATES][NSTATES];
   logic [15:0]        frame_no;
   int unsigned        next_state;
   logic               utterance_open;
   rsp_beat_type       expected_beats [$];

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic clear_trellis();
      foreach (trellis_score[s]) trellis_score[s] = '0;
      foreach (entry_frame[r, c]) entry_frame[r][c] = '0;
   endtask

   task automatic aligner_predict(input logic [1:0] op, input logic signed [31:0] score,
                                  input logic [3:0] idx, output rsp_beat_type beat);
      int unsigned s;
      beat = '0;
      case (op)
         OP_START: begin
            foreach (entry_frame[r, c]) entry_frame[r][c] = '0;
            frame_no = 16'd1;
            next_state = NSTATES - 1;
            utterance_open = 1'b1;
            trellis_score[0] = floor_reg;
            for (int k = 1; k < NSTATES; k++)
               trellis_score[k] = clamp32((longint'(trellis_score[k-1]) * 6) / 5);
            trellis_score[0] = score;
            beat.path_score = score;
         end
         OP_EMIT: begin
            if (!utterance_open) begin
               beat.order_error = 1'b1;
            end else begin
               s = next_state;
               if (s > 0) begin
                  if (trellis_score[s-1] > trellis_score[s]) begin
                     trellis_score[s] = trellis_score[s-1];
                     entry_frame[s][s] = frame_no;
                     for (int i = 1; i < s; i++) entry_frame[s][i] = entry_frame[s-1][i];
                  end
                  trellis_score[s] = clamp32(longint'(trellis_score[s]) + score);
                  next_state = s - 1;
               end else begin
                  trellis_score[0] = clamp32(longint'(trellis_score[0]) + score);
                  frame_no = frame_no + 16'd1;
                  next_state = NSTATES - 1;
                  beat.frame_end = 1'b1;
               end
               beat.path_score = trellis_score[s];
               beat.state_number = s[2:0];
            end
         end
         OP_READ: begin
            if (idx >= 1 && idx < NSTATES) beat.boundary_frame = entry_frame[NSTATES-1][idx];
            else if (idx == NSTATES) beat.boundary_frame = frame_no;
            beat.path_score = trellis_score[NSTATES-1];
            beat.state_number = 3'(NSTATES - 1);
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $realtime, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      rsp_beat_type got;
      if (reset) begin
         floor_reg = FLOOR_RESET;
         clear_trellis();
         frame_no = '0;
         next_state = NSTATES - 1;
         utterance_open = 1'b0;
         expected_beats.delete();
         errors = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_FLOOR) floor_reg = pwdata;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.path_score, rsp_mon.state_number, rsp_mon.frame_end,
                    rsp_mon.boundary_frame, rsp_mon.order_error};
            if (expected_beats.size() == 0) begin
               $display("%0t: result beat with nothing expected", $realtime);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               if (got.path_score !== want.path_score)
                  report_mismatch("path_score", want.path_score, got.path_score);
               if (got.state_number !== want.state_number)
                  report_mismatch("state_number", want.state_number, got.state_number);
               if (got.frame_end !== want.frame_end)
                  report_mismatch("frame_end", want.frame_end, got.frame_end);
               if (got.boundary_frame !== want.boundary_frame)
                  report_mismatch("boundary_frame", want.boundary_frame, got.boundary_frame);
               if (got.order_error !== want.order_error)
                  report_mismatch("order_error", want.order_error, got.order_error);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            aligner_predict(req_mon.op, req_mon.state_score, req_mon.boundary_index, want);
            expected_beats.push_back(want);
         end
      end
      pending = expected_beats.size();
   end

endmodule

/* bench/tb_left_right_viterbi_aligner_core.sv */
`timescale 1ns / 1ps

module tb_left_right_viterbi_aligner_core;
   import lrva_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   int errors, pending;
   bit no_idle = 1'b0;
   int quiet_cycles = 0;

   lrva_req_if req_bus();
   lrva_rsp_if rsp_bus();

   left_right_viterbi_aligner_core u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lrva_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // result side: random stall before each beat
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         #1;
         while (!rsp_bus.valid) begin
            @(negedge clock);
            #1;
         end
         @(negedge clock);
      end
   end

   task automatic send_beat(logic [1:0] op, logic [31:0] score, logic [3:0] idx);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.state_score <= score;
      req_bus.boundary_index <= idx;
      #1;
      while (!req_bus.ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_floor(logic [31:0] value);
      settle();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= CSR_FLOOR; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] draw_score();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'h7FFFFFFF;
         2: return 32'h80000000;
         default: return 32'($urandom_range(0, 4000)) - 32'd2000;
      endcase
   endfunction

   task automatic send_frame();
      for (int s = STATES_DEF - 1; s >= 0; s--) send_beat(OP_EMIT, draw_score(), '0);
   endtask

   initial begin
      int sent;
      int pick;
      req_bus.valid = 1'b0;
      req_bus.op = '0;
      req_bus.state_score = '0;
      req_bus.boundary_index = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      send_beat(OP_EMIT, 32'd5, 4'd0);
      send_beat(OP_READ, '0, 4'd8);
      send_beat(OP_READ, '0, 4'd3);
      send_beat(OP_UNUSED, 32'hFFFFFFFF, 4'hF);
      send_beat(OP_START, 32'h7FFFFFFF, 4'd0);
      send_beat(OP_EMIT, 32'h7FFFFFFF, '0);
      send_beat(OP_EMIT, 32'h80000000, '0);
      for (int s = 5; s >= 0; s--) send_beat(OP_EMIT, 32'd100, '0);
      send_frame();
      send_beat(OP_READ, '0, 4'd0);
      send_beat(OP_READ, '0, 4'd1);
      send_beat(OP_READ, '0, 4'd7);
      send_beat(OP_READ, '0, 4'd8);
      send_beat(OP_READ, '0, 4'd9);
      send_beat(OP_READ, '0, 4'd15);

      write_floor(32'h80000000);
      sent = 0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: write_floor(32'd0);
            2: write_floor(32'hFF000000);
            3: write_floor(32'h80000000 | $urandom_range(0, 32'h7FFFFFFF));
            4: write_floor(-32'($urandom_range(0, 5000)));
            default: ;
         endcase
         while (sent < (phase + 1) * 200) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if (sent > 500 && sent < 520) settle();
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               send_beat(OP_START, draw_score(), '0);
               sent++;
               repeat ($urandom_range(1, 4)) begin
                  send_frame();
                  sent += STATES_DEF;
                  if ($urandom_range(0, 1)) begin
                     send_beat(OP_READ, '0, 4'($urandom_range(0, 15)));
                     sent++;
                  end
               end
            end else begin
               send_beat(2'($urandom_range(0, 3)), $urandom, 4'($urandom_range(0, 15)));
               sent++;
            end
         end
      end
      no_idle = 1'b0;
      settle();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
